// ===== hdl/iidl_pkg.sv =====
package iidl_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    // stream packing, padded to whole bytes
    localparam int IN_TDATA_W  = ((IDX_W + DATA_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CNT_W + DATA_W + 7) / 8) * 8;
    localparam int IN_PAD_W    = IN_TDATA_W - IDX_W - DATA_W;
    localparam int OUT_PAD_W   = OUT_TDATA_W - CNT_W - DATA_W;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // what the row of cells does this cycle
    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_DELETE = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd              kind;
        logic [IDX_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } t_cell_cmd;

endpackage

// ===== hdl/iidl_cell.sv =====
module iidl_cell (
    input  logic                           i_clk,
    input  logic [iidl_pkg::IDX_W-1:0]     i_index,
    input  iidl_pkg::t_cell_cmd            i_cmd,
    input  logic [iidl_pkg::DATA_W-1:0]    i_left,
    input  logic [iidl_pkg::DATA_W-1:0]    i_right,
    output logic [iidl_pkg::DATA_W-1:0]    o_entry
);

    logic [iidl_pkg::DATA_W-1:0] r_entry;
    logic [iidl_pkg::DATA_W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_cmd.kind)
            iidl_pkg::CMD_LOAD: begin
                if (i_index == i_cmd.pos) n_entry = i_cmd.value;
            end
            iidl_pkg::CMD_INSERT: begin
                // later cells take their lower neighbor, the slot takes the value
                if (i_index > i_cmd.pos)       n_entry = i_left;
                else if (i_index == i_cmd.pos) n_entry = i_cmd.value;
            end
            iidl_pkg::CMD_DELETE: begin
                if (i_index >= i_cmd.pos) n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== hdl/indexed_insert_delete_list.sv =====
// Packed list of up to 16 signed 32-bit entries, held in a row of cells.
// Input stream (s_axis_*): one beat is one operation. tuser carries the
// operation code (append, insert, delete, read); tdata carries position and
// value. Output stream (m_axis_*): one beat per input beat, in order, with
// the status in tuser and the resulting count plus read data in tdata.
// Insert shifts every cell above the position up by one and delete shifts
// them down, all cells moving in the same cycle, so each operation is done
// in the cycle it is accepted. Result appears from an output register in
// the cycle after acceptance; a new beat is taken every cycle as long as
// that register is empty or is being drained, so throughput is 1 beat/cycle.
// Read data comes from a 16:1 select over the cell outputs.
// If the receiver stalls, the result is held and s_axis_tready drops until
// it is taken; the list state is untouched meanwhile.
// Reset (synchronous, active low) empties the list and the output register.
// Cell contents are not cleared; only entries below the count are visible.
// Refused operations (out of range, full, empty) leave the list unchanged
// and return zero read data.
module indexed_insert_delete_list (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [iidl_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // position, value, zero pad
    input  logic [iidl_pkg::OP_W-1:0]           s_axis_tuser,  // operation
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [iidl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // count, read_value, zero pad
    output logic [iidl_pkg::ST_W-1:0]           m_axis_tuser   // status
);

    // input beat fields
    iidl_pkg::t_op                 w_op;
    logic [iidl_pkg::IDX_W-1:0]    w_pos;
    logic [iidl_pkg::DATA_W-1:0]   w_value;
    logic                          w_accept;

    assign w_op    = iidl_pkg::t_op'(s_axis_tuser);
    assign w_pos   = s_axis_tdata[iidl_pkg::IDX_W-1:0];
    assign w_value = s_axis_tdata[iidl_pkg::IDX_W +: iidl_pkg::DATA_W];

    // list count and output register
    logic [iidl_pkg::CNT_W-1:0]    r_count;
    logic [iidl_pkg::CNT_W-1:0]    n_count;
    logic                          r_m_valid;
    iidl_pkg::t_status             r_status;
    iidl_pkg::t_status             n_status;
    logic [iidl_pkg::CNT_W-1:0]    r_out_count;
    logic [iidl_pkg::DATA_W-1:0]   r_rd;
    logic [iidl_pkg::DATA_W-1:0]   n_rd;

    // cell row
    iidl_pkg::t_cell_cmd           w_cmd;
    iidl_pkg::t_cmd                w_kind;
    logic [iidl_pkg::IDX_W-1:0]    w_cmd_pos;
    logic [iidl_pkg::DATA_W-1:0]   w_entry [iidl_pkg::DEPTH];
    logic [iidl_pkg::DATA_W-1:0]   w_left  [iidl_pkg::DEPTH];
    logic [iidl_pkg::DATA_W-1:0]   w_right [iidl_pkg::DEPTH];

    logic w_full;
    logic w_empty;
    logic w_in_range;

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_full     = (r_count == iidl_pkg::CNT_W'(iidl_pkg::DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_in_range = ({1'b0, w_pos} < r_count);

    // decode: status, next count, what the cells do
    always_comb begin
        n_status  = iidl_pkg::ST_DONE;
        n_count   = r_count;
        n_rd      = '0;
        w_kind    = iidl_pkg::CMD_NONE;
        w_cmd_pos = w_pos;
        case (w_op)
            iidl_pkg::OP_APPEND: begin
                if (w_full) begin
                    n_status = iidl_pkg::ST_FULL;
                end else begin
                    w_kind    = iidl_pkg::CMD_LOAD;
                    w_cmd_pos = r_count[iidl_pkg::IDX_W-1:0];
                    n_count   = r_count + 1'b1;
                end
            end
            iidl_pkg::OP_INSERT: begin
                if (w_empty) begin
                    // empty list: value lands in slot 0 whatever the position
                    w_kind    = iidl_pkg::CMD_LOAD;
                    w_cmd_pos = '0;
                    n_count   = iidl_pkg::CNT_W'(1);
                end else if (w_full) begin
                    n_status = iidl_pkg::ST_FULL;
                end else if (!w_in_range) begin
                    n_status = iidl_pkg::ST_RANGE;
                end else begin
                    w_kind  = iidl_pkg::CMD_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            iidl_pkg::OP_DELETE: begin
                if (w_empty) begin
                    n_status = iidl_pkg::ST_EMPTY;
                end else if (!w_in_range) begin
                    n_status = iidl_pkg::ST_RANGE;
                end else begin
                    w_kind  = iidl_pkg::CMD_DELETE;
                    n_count = r_count - 1'b1;
                end
            end
            iidl_pkg::OP_READ: begin
                if (w_empty) begin
                    n_status = iidl_pkg::ST_EMPTY;
                end else if (!w_in_range) begin
                    n_status = iidl_pkg::ST_RANGE;
                end else begin
                    n_rd = w_entry[w_pos];
                end
            end
            default: begin
                n_status = iidl_pkg::ST_DONE;
            end
        endcase
    end

    // cells only move on an accepted beat
    always_comb begin
        w_cmd.kind  = w_accept ? w_kind : iidl_pkg::CMD_NONE;
        w_cmd.pos   = w_cmd_pos;
        w_cmd.value = w_value;
    end

    // neighbor links; the row ends feed back their own entry
    always_comb begin
        for (int k = 0; k < iidl_pkg::DEPTH; k++) begin
            w_left[k]  = (k == 0) ? w_entry[k] : w_entry[(k == 0) ? 0 : k - 1];
            w_right[k] = (k == iidl_pkg::DEPTH - 1) ? w_entry[k]
                       : w_entry[(k == iidl_pkg::DEPTH - 1) ? k : k + 1];
        end
    end

    for (genvar g = 0; g < iidl_pkg::DEPTH; g++) begin : g_cell
        iidl_cell u_cell (
            .i_clk   (i_clk),
            .i_index (iidl_pkg::IDX_W'(g)),
            .i_cmd   (w_cmd),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .o_entry (w_entry[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_out_count <= n_count;
            r_rd        <= n_rd;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {{iidl_pkg::OUT_PAD_W{1'b0}}, r_rd, r_out_count};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= iidl_pkg::CNT_W'(iidl_pkg::DEPTH))
        else $error("list count above depth");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_status != iidl_pkg::ST_DONE) |-> (r_rd == '0))
        else $error("refused operation returned read data");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_out_count == r_count))
        else $error("reported count differs from list count");

    a_refused_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_status != iidl_pkg::ST_DONE) |=> $stable(r_count))
        else $error("refused operation changed the count");
`endif

endmodule
